[rtl/rvdec_pkg.sv]
package rvdec_pkg;

	// major opcodes, instruction bits 6:0
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_REG    = 7'b0110011;
	localparam logic [6:0] OP_SYSTEM = 7'b1110011;
	localparam logic [6:0] OP_FENCE  = 7'b0001111;

	// funct3 codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// branch funct3 codes
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// load and store width funct3 codes
	localparam logic [2:0] F3_LB   = 3'd0;
	localparam logic [2:0] F3_LH   = 3'd1;
	localparam logic [2:0] F3_LW   = 3'd2;
	localparam logic [2:0] F3_LBU  = 3'd4;
	localparam logic [2:0] F3_LHU  = 3'd5;

	// instruction format
	localparam logic [2:0] FMT_R = 3'd0;
	localparam logic [2:0] FMT_I = 3'd1;
	localparam logic [2:0] FMT_S = 3'd2;
	localparam logic [2:0] FMT_B = 3'd3;
	localparam logic [2:0] FMT_U = 3'd4;
	localparam logic [2:0] FMT_J = 3'd5;

	// first operand source
	localparam logic [1:0] ASRC_REG  = 2'd0;
	localparam logic [1:0] ASRC_PC   = 2'd1;
	localparam logic [1:0] ASRC_NONE = 2'd2;

	// second operand source
	localparam logic BSRC_REG = 1'b0;
	localparam logic BSRC_IMM = 1'b1;

	// alu operations
	localparam logic [3:0] ALU_ADD  = 4'd0;
	localparam logic [3:0] ALU_SUB  = 4'd1;
	localparam logic [3:0] ALU_SLL  = 4'd2;
	localparam logic [3:0] ALU_SLT  = 4'd3;
	localparam logic [3:0] ALU_SLTU = 4'd4;
	localparam logic [3:0] ALU_XOR  = 4'd5;
	localparam logic [3:0] ALU_SRL  = 4'd6;
	localparam logic [3:0] ALU_SRA  = 4'd7;
	localparam logic [3:0] ALU_OR   = 4'd8;
	localparam logic [3:0] ALU_AND  = 4'd9;
	localparam logic [3:0] ALU_PASSB = 4'd10;

	// writeback source
	localparam logic [1:0] WB_ALU = 2'd0;
	localparam logic [1:0] WB_MEM = 2'd1;
	localparam logic [1:0] WB_RA  = 2'd2;

	// control flow kind
	localparam logic [2:0] FLOW_NONE   = 3'd0;
	localparam logic [2:0] FLOW_JAL    = 3'd1;
	localparam logic [2:0] FLOW_JALR   = 3'd2;
	localparam logic [2:0] FLOW_BRANCH = 3'd3;
	localparam logic [2:0] FLOW_TRAP   = 3'd4;

	// branch compare
	localparam logic [2:0] CMP_EQ  = 3'd0;
	localparam logic [2:0] CMP_NE  = 3'd1;
	localparam logic [2:0] CMP_LT  = 3'd2;
	localparam logic [2:0] CMP_GE  = 3'd3;
	localparam logic [2:0] CMP_LTU = 3'd4;
	localparam logic [2:0] CMP_GEU = 3'd5;

	// memory access size
	localparam logic [1:0] MSIZE_BYTE = 2'd0;
	localparam logic [1:0] MSIZE_HALF = 2'd1;
	localparam logic [1:0] MSIZE_WORD = 2'd2;

	// decoded control word
	typedef struct packed {
		logic [2:0] format_type;
		logic       rd_write_en;
		logic [1:0] operand_a_source;
		logic       operand_b_source;
		logic [3:0] alu_operation;
		logic [1:0] writeback_source;
		logic [2:0] flow_kind;
		logic [2:0] compare_operation;
		logic       store_en;
		logic [1:0] mem_size;
		logic       mem_sign_extend;
		logic       instr_legal;
	} ctrl_t;

	// alu operation for a funct3 with the alternate bits clear
	function automatic logic [3:0] alu_of_funct3(input logic [2:0] f3);
		logic [3:0] op;
		case (f3)
			F3_ADD:  op = ALU_ADD;
			F3_SLL:  op = ALU_SLL;
			F3_SLT:  op = ALU_SLT;
			F3_SLTU: op = ALU_SLTU;
			F3_XOR:  op = ALU_XOR;
			F3_SRL:  op = ALU_SRL;
			F3_OR:   op = ALU_OR;
			default: op = ALU_AND;
		endcase
		return op;
	endfunction

endpackage

[rtl/rvdec_decode.sv]
module rvdec_decode (
	input  logic [31:0]         instruction,
	output rvdec_pkg::ctrl_t    ctrl
);

	logic [6:0] opcode;
	logic [2:0] funct3;
	logic       alt;

	assign opcode = instruction[6:0];
	assign funct3 = instruction[14:12];
	assign alt    = |instruction[31:30];

	// opcode and funct3 decode, unused flags left at zero
	always_comb begin
		ctrl = '0;
		case (opcode)
			rvdec_pkg::OP_LUI: begin
				ctrl.format_type      = rvdec_pkg::FMT_U;
				ctrl.rd_write_en      = 1'b1;
				ctrl.operand_a_source = rvdec_pkg::ASRC_NONE;
				ctrl.operand_b_source = rvdec_pkg::BSRC_IMM;
				ctrl.alu_operation    = rvdec_pkg::ALU_PASSB;
				ctrl.instr_legal      = 1'b1;
			end
			rvdec_pkg::OP_AUIPC: begin
				ctrl.format_type      = rvdec_pkg::FMT_U;
				ctrl.rd_write_en      = 1'b1;
				ctrl.operand_a_source = rvdec_pkg::ASRC_PC;
				ctrl.operand_b_source = rvdec_pkg::BSRC_IMM;
				ctrl.alu_operation    = rvdec_pkg::ALU_ADD;
				ctrl.instr_legal      = 1'b1;
			end
			rvdec_pkg::OP_JAL: begin
				ctrl.format_type      = rvdec_pkg::FMT_J;
				ctrl.rd_write_en      = 1'b1;
				ctrl.writeback_source = rvdec_pkg::WB_RA;
				ctrl.flow_kind        = rvdec_pkg::FLOW_JAL;
				ctrl.instr_legal      = 1'b1;
			end
			rvdec_pkg::OP_JALR: begin
				if (funct3 == rvdec_pkg::F3_ADD) begin
					ctrl.format_type      = rvdec_pkg::FMT_I;
					ctrl.rd_write_en      = 1'b1;
					ctrl.writeback_source = rvdec_pkg::WB_RA;
					ctrl.flow_kind        = rvdec_pkg::FLOW_JALR;
					ctrl.instr_legal      = 1'b1;
				end
			end
			rvdec_pkg::OP_BRANCH: begin
				ctrl.format_type = rvdec_pkg::FMT_B;
				ctrl.flow_kind   = rvdec_pkg::FLOW_BRANCH;
				ctrl.instr_legal = 1'b1;
				case (funct3)
					rvdec_pkg::F3_BEQ:  ctrl.compare_operation = rvdec_pkg::CMP_EQ;
					rvdec_pkg::F3_BNE:  ctrl.compare_operation = rvdec_pkg::CMP_NE;
					rvdec_pkg::F3_BLT:  ctrl.compare_operation = rvdec_pkg::CMP_LT;
					rvdec_pkg::F3_BGE:  ctrl.compare_operation = rvdec_pkg::CMP_GE;
					rvdec_pkg::F3_BLTU: ctrl.compare_operation = rvdec_pkg::CMP_LTU;
					rvdec_pkg::F3_BGEU: ctrl.compare_operation = rvdec_pkg::CMP_GEU;
					default: begin
						ctrl = '0;
					end
				endcase
			end
			rvdec_pkg::OP_LOAD: begin
				if (funct3 == rvdec_pkg::F3_LB || funct3 == rvdec_pkg::F3_LH ||
				    funct3 == rvdec_pkg::F3_LW || funct3 == rvdec_pkg::F3_LBU ||
				    funct3 == rvdec_pkg::F3_LHU) begin
					ctrl.format_type      = rvdec_pkg::FMT_I;
					ctrl.rd_write_en      = 1'b1;
					ctrl.operand_b_source = rvdec_pkg::BSRC_IMM;
					ctrl.alu_operation    = rvdec_pkg::ALU_ADD;
					ctrl.writeback_source = rvdec_pkg::WB_MEM;
					ctrl.mem_size         = funct3[1:0];
					ctrl.mem_sign_extend  = (funct3 == rvdec_pkg::F3_LB) ||
					                        (funct3 == rvdec_pkg::F3_LH);
					ctrl.instr_legal      = 1'b1;
				end
			end
			rvdec_pkg::OP_STORE: begin
				if (funct3 == rvdec_pkg::F3_LB || funct3 == rvdec_pkg::F3_LH ||
				    funct3 == rvdec_pkg::F3_LW) begin
					ctrl.format_type      = rvdec_pkg::FMT_S;
					ctrl.operand_b_source = rvdec_pkg::BSRC_IMM;
					ctrl.alu_operation    = rvdec_pkg::ALU_ADD;
					ctrl.store_en         = 1'b1;
					ctrl.mem_size         = funct3[1:0];
					ctrl.instr_legal      = 1'b1;
				end
			end
			rvdec_pkg::OP_IMM: begin
				ctrl.format_type      = rvdec_pkg::FMT_I;
				ctrl.rd_write_en      = 1'b1;
				ctrl.operand_b_source = rvdec_pkg::BSRC_IMM;
				ctrl.alu_operation    = rvdec_pkg::alu_of_funct3(funct3);
				if (funct3 == rvdec_pkg::F3_SRL && alt) begin
					ctrl.alu_operation = rvdec_pkg::ALU_SRA;
				end
				ctrl.instr_legal      = 1'b1;
			end
			rvdec_pkg::OP_REG: begin
				ctrl.format_type   = rvdec_pkg::FMT_R;
				ctrl.rd_write_en   = 1'b1;
				ctrl.alu_operation = rvdec_pkg::alu_of_funct3(funct3);
				if (alt && funct3 == rvdec_pkg::F3_ADD) begin
					ctrl.alu_operation = rvdec_pkg::ALU_SUB;
				end else if (alt && funct3 == rvdec_pkg::F3_SRL) begin
					ctrl.alu_operation = rvdec_pkg::ALU_SRA;
				end
				ctrl.instr_legal   = 1'b1;
			end
			rvdec_pkg::OP_SYSTEM: begin
				if (funct3 == rvdec_pkg::F3_ADD) begin
					ctrl.format_type = rvdec_pkg::FMT_I;
					ctrl.flow_kind   = rvdec_pkg::FLOW_TRAP;
					ctrl.instr_legal = 1'b1;
				end
			end
			// fence is not supported and decodes as illegal
			rvdec_pkg::OP_FENCE: begin
				ctrl = '0;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

[rtl/rv32i_main_control_decoder_unit.sv]
// RV32I main control decoder. Each request carries one 32-bit instruction word and
// yields one set of control flags for a single-cycle datapath. A request passes
// through an input register, the opcode/funct3 decode, and a result register
// that drives the result ports; a new request is taken every cycle while results
// are being taken, and the block keeps taking requests until both stages hold an
// unconsumed word. Unknown encodings, FENCE and SYSTEM with nonzero funct3 give
// all flags zero with instr_legal low. SUB and SRA/SRAI are selected when
// instruction bits 31:30 are not both zero. There is no configuration and no
// state beyond the two pipeline stages.
module rv32i_main_control_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_ready,
	input  logic [31:0] instruction,
	output logic        ctrl_valid,
	input  logic        ctrl_ready,
	output logic [2:0]  format_type,
	output logic        rd_write_en,
	output logic [1:0]  operand_a_source,
	output logic        operand_b_source,
	output logic [3:0]  alu_operation,
	output logic [1:0]  writeback_source,
	output logic [2:0]  flow_kind,
	output logic [2:0]  compare_operation,
	output logic        store_en,
	output logic [1:0]  mem_size,
	output logic        mem_sign_extend,
	output logic        instr_legal
);

	logic             valid_s1;
	logic [31:0]      instr_s1;
	logic             valid_s2;
	rvdec_pkg::ctrl_t ctrl_s2;
	rvdec_pkg::ctrl_t ctrl_dec;
	logic             adv_s2;
	logic             adv_s1;

	// stage advance, result register frees when taken
	assign adv_s2      = !valid_s2 || ctrl_ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign instr_ready = adv_s1;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= instr_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (adv_s1 && instr_valid) begin
			instr_s1 <= instruction;
		end
	end

	// decode
	rvdec_decode u_decode (
		.instruction (instr_s1),
		.ctrl        (ctrl_dec)
	);

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			ctrl_s2 <= ctrl_dec;
		end
	end

	// result ports
	assign ctrl_valid        = valid_s2;
	assign format_type       = ctrl_s2.format_type;
	assign rd_write_en       = ctrl_s2.rd_write_en;
	assign operand_a_source  = ctrl_s2.operand_a_source;
	assign operand_b_source  = ctrl_s2.operand_b_source;
	assign alu_operation     = ctrl_s2.alu_operation;
	assign writeback_source  = ctrl_s2.writeback_source;
	assign flow_kind         = ctrl_s2.flow_kind;
	assign compare_operation = ctrl_s2.compare_operation;
	assign store_en          = ctrl_s2.store_en;
	assign mem_size          = ctrl_s2.mem_size;
	assign mem_sign_extend   = ctrl_s2.mem_sign_extend;
	assign instr_legal       = ctrl_s2.instr_legal;

	// an empty result register never holds back a request
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl_valid |-> instr_ready)
		else $error("request stalled with empty result register");

	// illegal words carry no control flags
	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_valid && !instr_legal) |-> (format_type == rvdec_pkg::FMT_R &&
		!rd_write_en && operand_a_source == rvdec_pkg::ASRC_REG && !store_en &&
		alu_operation == rvdec_pkg::ALU_ADD && flow_kind == rvdec_pkg::FLOW_NONE &&
		mem_size == rvdec_pkg::MSIZE_BYTE))
		else $error("illegal instruction with control flags set");

	// a taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_valid && ctrl_ready && !valid_s1) |=> !ctrl_valid)
		else $error("result repeated");

	// stores and only stores write memory
	a_store_format: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_valid && store_en) |-> (format_type == rvdec_pkg::FMT_S && !rd_write_en))
		else $error("memory write outside a store");

endmodule
